### sv/lefs_pkg.sv
// shared types, codes, constants and the breath weight table for the led effect sequencer
package lefs_pkg;

  localparam int NUM_LEDS_DEFAULT      = 12;
  localparam int BREATH_PERIOD_DEFAULT = 200;

  localparam logic [7:0] STATIC_DELAY_MAX   = 8'd250;
  localparam logic [7:0] STATIC_DELAY_RESET = 8'd4;
  localparam logic [6:0] BLINK_HALF_RESET   = 7'd20;
  localparam logic [5:0] ROLL_STEP_RESET    = 6'd5;

  localparam int DIV_DIVIDEND_W = 8;
  localparam int DIV_DIVISOR_W  = 8;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EFF_STATIC = 2'd0,
    EFF_BLINK  = 2'd1,
    EFF_ROLL   = 2'd2,
    EFF_BREATH = 2'd3
  } effect_t;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_ALL_OFF = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_STATIC_DELAY = 2'd0;
  localparam logic [1:0] CFG_BLINK_HALF   = 2'd1;
  localparam logic [1:0] CFG_ROLL_STEP    = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                      start;
    logic [DIV_DIVIDEND_W-1:0] dividend;
    logic [DIV_DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic [DIV_DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // raised cosine over the first quarter turn, q8
  localparam logic [7:0] QUARTER_WT [65] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
    8'd22,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd60,  8'd62,  8'd65,  8'd68,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd119, 8'd122, 8'd125,
    8'd128
  };

  // full-turn weight from the quarter table by symmetry, 0..256
  function automatic logic [8:0] weight_of(input logic [7:0] idx);
    logic [7:0] a;
    logic [7:0] m;
    a = (idx > 8'd128) ? 8'(9'd256 - {1'b0, idx}) : idx;
    m = 8'd128 - a;
    if (a <= 8'd64) begin
      return {1'b0, QUARTER_WT[a[6:0]]};
    end else begin
      return 9'd256 - {1'b0, QUARTER_WT[m[6:0]]};
    end
  endfunction

endpackage

### sv/lefs_in_if.sv
// input item channel
interface lefs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] led_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [1:0] effect;

  modport source (output valid, mode, led_index, red_in, green_in, blue_in, effect,
                  input ready);
  modport sink (input valid, mode, led_index, red_in, green_in, blue_in, effect,
                output ready);
endinterface

### sv/lefs_out_if.sv
// result item channel
interface lefs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] position;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last;

  modport source (output valid, kind, position, red_out, green_out, blue_out, last,
                  input ready);
  modport sink (input valid, kind, position, red_out, green_out, blue_out, last,
                output ready);
endinterface

### sv/lefs_cfg_if.sv
// configuration write channel
interface lefs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/lefs_frame_mem.sv
// frame store: one rgb word per led, registered read, per-row valid bits for the reset clear
module lefs_frame_mem #(
  parameter int DEPTH = lefs_pkg::NUM_LEDS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  lefs_pkg::pixel_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output lefs_pkg::pixel_t rdata
);
  import lefs_pkg::*;

  pixel_t           mem [DEPTH];
  logic [DEPTH-1:0] filled;
  pixel_t           rd_word;
  logic             rd_filled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (we) begin
        filled[waddr] <= 1'b1;
      end
      if (re) begin
        rd_filled <= filled[raddr];
      end
    end
  end

  // a row never written since reset reads as off
  assign rdata = rd_filled ? rd_word : '0;

endmodule

### sv/lefs_divider.sv
// restoring divider, one quotient bit per cycle
module lefs_divider (
  input  logic               clk,
  input  logic               rst,
  input  lefs_pkg::div_req_t req,
  output lefs_pkg::div_rsp_t rsp
);
  import lefs_pkg::*;

  localparam int CW = $clog2(DIV_DIVIDEND_W);

  logic                      busy;
  logic                      done;
  logic [CW-1:0]             cnt;
  logic [DIV_DIVISOR_W-1:0]  rem;
  logic [DIV_DIVISOR_W-1:0]  dvs;
  logic [DIV_DIVIDEND_W-1:0] quo;
  logic [DIV_DIVISOR_W:0]    shifted;
  logic                      fits;

  assign shifted = {rem, quo[DIV_DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= req.divisor;
        quo  <= req.dividend;
      end else if (busy) begin
        rem <= fits ? DIV_DIVISOR_W'(shifted - {1'b0, dvs}) : shifted[DIV_DIVISOR_W-1:0];
        quo <= {quo[DIV_DIVIDEND_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### sv/led_effect_frame_sequencer.sv
// led effect frame sequencer top level: effect control, phase, config and result register
// Colour writes, effect selects and ignored items leave the block idle and ready. A tick
// that sends a frame reads each led from the single read port of the frame store and then
// loads it into the result register (read, then load), one led at a time, and ends with a
// refresh command; roll first waits in the division state for the one-bit-a-cycle divider
// that works out the rotation, and breath passes through that state once to look up the
// weight for its index, which comes from a multiply by the reciprocal of the period.
// Blink's all-off is a single command, and a tick that sends nothing leaves the block idle.
// Result stalls hold the load and command states. The store's reset clear is done with
// per-led valid bits, so there is no clearing pass and items are taken right after reset.
module led_effect_frame_sequencer #(
  parameter int NUM_LEDS      = lefs_pkg::NUM_LEDS_DEFAULT,
  parameter int BREATH_PERIOD = lefs_pkg::BREATH_PERIOD_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  lefs_in_if.sink    items,
  lefs_out_if.source results,
  lefs_cfg_if.sink   cfg
);
  import lefs_pkg::*;

  localparam int AW   = $clog2(NUM_LEDS);
  localparam int HALF = NUM_LEDS / 2;

  // weight index phase*256/period as (phase * ceil(2^s/period)) >> (s-8), exact for 8-bit phase
  localparam int BR_SHIFT   = 16 + $clog2(BREATH_PERIOD);
  localparam int BR_RECIP_W = 18;
  localparam logic [BR_RECIP_W-1:0] BR_RECIP =
    BR_RECIP_W'(((64'd1 << BR_SHIFT) + 64'(BREATH_PERIOD) - 64'd1) / 64'(BREATH_PERIOD));

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_LOAD = 5'b01000,
    S_CMD  = 5'b10000
  } state_t;

  state_t     state;
  effect_t    effect_sel;
  logic [7:0] phase;
  logic [7:0] static_delay;
  logic [6:0] blink_half;
  logic [5:0] roll_step;
  logic [AW-1:0] p;
  logic [AW-1:0] r;
  logic [8:0] weight;
  logic [7:0] breath_idx;
  kind_t      cmd_kind;

  logic       out_valid;
  kind_t      out_kind;
  logic [3:0] out_pos;
  pixel_t     out_pix;
  logic       out_last;

  logic       in_xfer;
  logic       out_free;
  logic       load_out;
  mode_t      in_mode;
  logic [7:0] delay_eff;
  logic [7:0] blink_next;
  logic [BR_RECIP_W+7:0] breath_prod;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  pixel_t     rd_pix;
  pixel_t     shown;
  logic [AW-1:0] src;
  logic       mem_we;

  logic [AW:0] pw, basew, dstw, rp1, iw;

  assign in_mode  = mode_t'(items.mode);
  assign in_xfer  = items.valid && items.ready;
  assign out_free = !out_valid || results.ready;
  assign load_out = (state == S_LOAD || state == S_CMD) && out_free;
  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign delay_eff = (static_delay > STATIC_DELAY_MAX) ? STATIC_DELAY_MAX : static_delay;

  assign breath_prod = phase * BR_RECIP;

  // blink wraps back to one once it reaches twice the half period, then counts on
  always_comb begin
    if (phase != 8'd1 && phase != {1'b0, blink_half} && phase >= {blink_half, 1'b0}) begin
      blink_next = 8'd1;
    end else begin
      blink_next = phase + 8'd1;
    end
  end

  assign mem_we = in_xfer && in_mode == MODE_WRITE && 32'(items.led_index) < NUM_LEDS;

  assign div_req.start = in_xfer && in_mode == MODE_TICK && effect_sel == EFF_ROLL;
  assign div_req.dividend = DIV_DIVIDEND_W'(phase);
  assign div_req.divisor  = (roll_step == 6'd0) ? DIV_DIVISOR_W'(1)
                                                : DIV_DIVISOR_W'(roll_step);

  lefs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // roll: output slot dst of a half shows the led at (dst - r - 1) mod half
  always_comb begin
    pw    = {1'b0, p};
    basew = (pw < (AW+1)'(HALF)) ? '0 : (AW+1)'(HALF);
    dstw  = pw - basew;
    rp1   = {1'b0, r} + 1'b1;
    if (dstw >= rp1) begin
      iw = dstw - rp1;
    end else begin
      iw = dstw + (AW+1)'(HALF) - rp1;
    end
    src = p;
    if (effect_sel == EFF_ROLL && pw < (AW+1)'(2 * HALF)) begin
      src = AW'(basew + iw);
    end
  end

  lefs_frame_mem #(.DEPTH(NUM_LEDS)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (AW'(items.led_index)),
    .wdata ({items.red_in, items.green_in, items.blue_in}),
    .re    (state == S_READ),
    .raddr (src),
    .rdata (rd_pix)
  );

  function automatic logic [7:0] scale(input logic [7:0] b, input logic [8:0] w);
    logic [16:0] prod;
    prod = b * w;
    return (prod[16:8] > 9'd255) ? 8'd255 : prod[15:8];
  endfunction

  always_comb begin
    shown = rd_pix;
    if (effect_sel == EFF_BREATH) begin
      shown.red   = scale(rd_pix.red, weight);
      shown.green = scale(rd_pix.green, weight);
      shown.blue  = scale(rd_pix.blue, weight);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      effect_sel   <= EFF_STATIC;
      phase        <= '0;
      static_delay <= STATIC_DELAY_RESET;
      blink_half   <= BLINK_HALF_RESET;
      roll_step    <= ROLL_STEP_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_STATIC_DELAY: static_delay <= cfg.data;
          CFG_BLINK_HALF:   blink_half   <= cfg.data[6:0];
          CFG_ROLL_STEP:    roll_step    <= cfg.data[5:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_mode)
              MODE_SELECT: begin
                effect_sel <= effect_t'(items.effect);
                phase      <= '0;
              end
              MODE_TICK: begin
                unique case (effect_sel)
                  EFF_STATIC: begin
                    if (phase <= delay_eff) begin
                      phase <= phase + 8'd1;
                    end
                    if (phase == delay_eff) begin
                      p     <= '0;
                      state <= S_READ;
                    end
                  end
                  EFF_BLINK: begin
                    phase <= blink_next;
                    if (phase == 8'd1) begin
                      p     <= '0;
                      state <= S_READ;
                    end else if (phase == {1'b0, blink_half}) begin
                      cmd_kind <= KIND_ALL_OFF;
                      state    <= S_CMD;
                    end
                  end
                  EFF_ROLL: state <= S_DIV;
                  EFF_BREATH: begin
                    breath_idx <= breath_prod[BR_SHIFT-8 +: 8];
                    state      <= S_DIV;
                  end
                endcase
              end
              MODE_WRITE, MODE_NONE: ;
            endcase
          end
        end
        S_DIV: begin
          if (effect_sel == EFF_ROLL) begin
            if (div_rsp.done) begin
              if (div_rsp.quotient >= DIV_DIVIDEND_W'(HALF)) begin
                r     <= '0;
                phase <= 8'd1;
              end else begin
                r     <= AW'(div_rsp.quotient);
                phase <= phase + 8'd1;
              end
              p     <= '0;
              state <= S_READ;
            end
          end else begin
            weight <= weight_of(breath_idx);
            phase  <= (32'(phase) > BREATH_PERIOD) ? 8'd0 : phase + 8'd1;
            p      <= '0;
            state  <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            out_kind  <= KIND_PIXEL;
            out_pos   <= 4'(p);
            out_pix   <= shown;
            out_last  <= 1'b0;
            if (32'(p) == NUM_LEDS - 1) begin
              cmd_kind <= KIND_REFRESH;
              state    <= S_CMD;
            end else begin
              p     <= p + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_CMD: begin
          if (out_free) begin
            out_kind  <= cmd_kind;
            out_pos   <= '0;
            out_pix   <= '0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.kind      = out_kind;
  assign results.position  = out_pos;
  assign results.red_out   = out_pix.red;
  assign results.green_out = out_pix.green;
  assign results.blue_out  = out_pix.blue;
  assign results.last      = out_last;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the division wait");

  a_last_on_commands: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.last == (results.kind != KIND_PIXEL)))
    else $error("last flag does not match result kind");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> 32'(src) < NUM_LEDS)
    else $error("frame store read beyond the led count");

  a_breath_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && effect_sel == EFF_BREATH) |-> 32'(phase) <= BREATH_PERIOD + 1)
    else $error("breath phase ran past its period");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_LOAD)
    else $error("read data not taken in the following cycle");

endmodule

### dv/testbench.sv
// self-checking testbench for the led effect frame sequencer: random traffic, frame prediction
module testbench;
  import lefs_pkg::*;

  localparam int NUM_LEDS         = NUM_LEDS_DEFAULT;
  localparam int HALF_LEDS        = NUM_LEDS / 2;
  localparam int BREATH_PERIOD    = BREATH_PERIOD_DEFAULT;
  localparam int STATIC_DELAY_CAP = 250;
  localparam int SETTLE_CYCLES    = 64;
  localparam int HOLD_CYCLES      = 300;
  localparam int CYCLE_LIMIT      = 500000;
  localparam real PI              = 3.14159265358979;

  typedef struct {
    logic [1:0] mode;
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] effect;
  } led_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_result_t;

  logic clk = 1'b0;
  logic rst;

  lefs_in_if  item_ch ();
  lefs_out_if result_ch ();
  lefs_cfg_if cfg_ch ();

  led_effect_frame_sequencer uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // predicted block state
  pixel_t     colours [NUM_LEDS];
  pixel_t     shown [NUM_LEDS];
  effect_t    active_effect;
  logic [7:0] phase;
  logic [7:0] delay_reg;
  logic [6:0] blink_half_reg;
  logic [5:0] roll_step_reg;

  led_item_t   pending_items [$];
  led_result_t expected_results [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int error_count    = 0;
  int items_queued   = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int frames_seen    = 0;
  int all_off_seen   = 0;
  int cycle_count    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // raised cosine dimming weight in q8, 0..256
  function automatic int breath_weight(input int idx);
    real w;
    w = 128.0 * (1.0 - $cos(2.0 * PI * idx / 256.0));
    return $rtoi(w + 0.5);
  endfunction

  function automatic logic [7:0] dim_byte(input logic [7:0] b, input int wt);
    int v;
    v = (int'(b) * wt) >> 8;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic void queue_frame();
    for (int p = 0; p < NUM_LEDS; p++) begin
      expected_results.push_back('{KIND_PIXEL, 4'(p), shown[p].red, shown[p].green,
                                   shown[p].blue, 1'b0});
    end
    expected_results.push_back('{KIND_REFRESH, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1});
  endfunction

  function automatic void advance_tick();
    int limit;
    int step;
    int rot;
    int wt;
    case (active_effect)
      EFF_STATIC: begin
        limit = (delay_reg > STATIC_DELAY_CAP) ? STATIC_DELAY_CAP : delay_reg;
        if (phase == limit) begin
          shown = colours;
          queue_frame();
          phase++;
        end else if (phase < limit) begin
          phase++;
        end
      end
      EFF_BLINK: begin
        if (phase == 1) begin
          shown = colours;
          queue_frame();
        end else if (phase == blink_half_reg) begin
          expected_results.push_back('{KIND_ALL_OFF, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        end else if (phase >= 2 * blink_half_reg) begin
          phase = 0;
        end
        phase++;
      end
      EFF_ROLL: begin
        step = (roll_step_reg == 0) ? 1 : roll_step_reg;
        rot = int'(phase) / step;
        if (rot >= HALF_LEDS) begin
          phase = 0;
          rot = 0;
        end
        shown = colours;
        // each half rotates on its own
        for (int h = 0; h < 2; h++) begin
          for (int i = 0; i < HALF_LEDS; i++) begin
            shown[h * HALF_LEDS + (i + rot + 1) % HALF_LEDS] = colours[h * HALF_LEDS + i];
          end
        end
        queue_frame();
        phase++;
      end
      default: begin
        wt = breath_weight((int'(phase) * 256 / BREATH_PERIOD) % 256);
        for (int p = 0; p < NUM_LEDS; p++) begin
          shown[p].red   = dim_byte(colours[p].red, wt);
          shown[p].green = dim_byte(colours[p].green, wt);
          shown[p].blue  = dim_byte(colours[p].blue, wt);
        end
        queue_frame();
        if (phase > BREATH_PERIOD) phase = 0;
        else phase++;
      end
    endcase
  endfunction

  function automatic void apply_item(input led_item_t it);
    case (it.mode)
      MODE_TICK: advance_tick();
      MODE_WRITE: begin
        if (it.led_index < NUM_LEDS) colours[it.led_index] = '{it.red, it.green, it.blue};
      end
      MODE_SELECT: begin
        active_effect = effect_t'(it.effect);
        phase = 0;
      end
      default: ;
    endcase
  endfunction

  // stimulus helpers
  function automatic led_item_t random_item(input logic [1:0] mode);
    led_item_t it;
    it.mode      = mode;
    it.led_index = 4'($urandom_range(15));
    it.red       = 8'($urandom);
    it.green     = 8'($urandom);
    it.blue      = 8'($urandom);
    it.effect    = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic void queue_item(input led_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_write(input logic [3:0] idx, input logic [7:0] r, g, b);
    led_item_t it;
    it = random_item(MODE_WRITE);
    it.led_index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    queue_item(it);
  endfunction

  function automatic void push_random_write();
    led_item_t it;
    it = random_item(MODE_WRITE);
    if ($urandom_range(7) != 0) it.led_index = 4'($urandom_range(NUM_LEDS - 1));
    queue_item(it);
  endfunction

  function automatic void push_select(input effect_t e);
    led_item_t it;
    it = random_item(MODE_SELECT);
    it.effect = e;
    queue_item(it);
  endfunction

  // run of ticks with the odd colour write mixed in
  function automatic void push_ticks(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(7) == 0) push_random_write();
      queue_item(random_item(MODE_TICK));
    end
  endfunction

  // mostly select, writes, then a tick run; static and blink runs are long enough to go round the effect
  function automatic void add_sequences(input int target);
    int stop_at;
    int run_len;
    int step;
    effect_t e;
    stop_at = items_queued + target;
    while (items_queued < stop_at) begin
      if ($urandom_range(4) == 0) begin
        queue_item(random_item(2'($urandom_range(3))));
      end else begin
        e = effect_t'(2'($urandom_range(3)));
        push_select(e);
        repeat ($urandom_range(3)) push_random_write();
        step = (roll_step_reg == 0) ? 1 : roll_step_reg;
        case (e)
          EFF_STATIC: begin
            run_len = ((delay_reg > STATIC_DELAY_CAP) ? STATIC_DELAY_CAP : delay_reg)
                      + $urandom_range(1, 3);
          end
          EFF_BLINK: run_len = 2 * blink_half_reg + $urandom_range(1, 4);
          EFF_ROLL: run_len = $urandom_range(1, HALF_LEDS * step + 2);
          default: run_len = $urandom_range(1, 12);
        endcase
        push_ticks(run_len);
      end
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_STATIC_DELAY: delay_reg = val;
      CFG_BLINK_HALF: blink_half_reg = val[6:0];
      default: roll_step_reg = val[5:0];
    endcase
  endtask

  task automatic configure(input logic [7:0] delay_val, blink_val, roll_val);
    write_reg(CFG_STATIC_DELAY, delay_val);
    write_reg(CFG_BLINK_HALF, blink_val);
    write_reg(CFG_ROLL_STEP, roll_val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain(input bit settle);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // item driver
  always @(posedge clk) begin : item_driver
    led_item_t taken;
    led_item_t next_item;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        taken.mode      = item_ch.mode;
        taken.led_index = item_ch.led_index;
        taken.red       = item_ch.red_in;
        taken.green     = item_ch.green_in;
        taken.blue      = item_ch.blue_in;
        taken.effect    = item_ch.effect;
        apply_item(taken);
        items_accepted++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          item_ch.valid     <= 1'b1;
          item_ch.mode      <= next_item.mode;
          item_ch.led_index <= next_item.led_index;
          item_ch.red_in    <= next_item.red;
          item_ch.green_in  <= next_item.green;
          item_ch.blue_in   <= next_item.blue;
          item_ch.effect    <= next_item.effect;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long result hold-off, started on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    led_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d position %0d",
                 result_ch.kind, result_ch.position);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, result_ch.kind);
          check_field("position", want.position, result_ch.position);
          check_field("red_out", want.red, result_ch.red_out);
          check_field("green_out", want.green, result_ch.green_out);
          check_field("blue_out", want.blue, result_ch.blue_out);
          check_field("last", want.last, result_ch.last);
          results_checked++;
          if (want.kind == KIND_REFRESH) frames_seen++;
          if (want.kind == KIND_ALL_OFF) all_off_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.mode      = MODE_TICK;
    item_ch.led_index = '0;
    item_ch.red_in    = '0;
    item_ch.green_in  = '0;
    item_ch.blue_in   = '0;
    item_ch.effect    = EFF_STATIC;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_STATIC_DELAY;
    cfg_ch.data       = '0;
    for (int p = 0; p < NUM_LEDS; p++) colours[p] = '0;
    active_effect  = EFF_STATIC;
    phase          = '0;
    delay_reg      = 8'd4;
    blink_half_reg = 7'd20;
    roll_step_reg  = 6'd5;
    send_idle_pct  = 17;
    recv_idle_pct  = 64;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: colour extremes, ignored writes, unused mode, every effect at reset settings
    push_write(4'd0, 8'd255, 8'd255, 8'd255);
    push_write(4'd11, 8'd255, 8'd0, 8'd128);
    push_write(4'd5, 8'h12, 8'h34, 8'h56);
    push_write(4'd6, 8'd1, 8'd2, 8'd3);
    push_write(4'(NUM_LEDS), 8'd255, 8'd255, 8'd255);
    push_write(4'd15, 8'd170, 8'd85, 8'd255);
    queue_item(random_item(MODE_NONE));
    repeat (6) queue_item(random_item(MODE_TICK));
    push_select(EFF_BLINK);
    repeat (2) queue_item(random_item(MODE_TICK));
    push_select(EFF_ROLL);
    repeat (2) queue_item(random_item(MODE_TICK));
    push_select(EFF_BREATH);
    repeat (2) queue_item(random_item(MODE_TICK));
    push_select(EFF_STATIC);
    queue_item(random_item(MODE_TICK));
    drain(1'b1);

    // low settings, slow receiver, with one long result stall
    configure(8'd0, 8'd2, 8'd1);
    add_sequences(25);
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    push_select(EFF_ROLL);
    push_ticks(12);
    add_sequences(25);
    drain(1'b1);

    // mid settings and a zero roll step, slow sender, one full pause for results
    send_idle_pct = 64;
    recv_idle_pct = 17;
    configure(8'd9, 8'd5, 8'd0);
    add_sequences(25);
    drain(1'b0);
    add_sequences(25);
    drain(1'b1);

    // full rate with register values past their usual range (static delay above its cap,
    // upper bits dropped), then a whole breath cycle through its wrap
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(8'd255, 8'hFF, 8'hBF);
    push_select(EFF_STATIC);
    push_ticks(4);
    push_select(EFF_BLINK);
    push_ticks(3);
    push_select(EFF_ROLL);
    push_ticks(3);
    push_select(EFF_BREATH);
    repeat (BREATH_PERIOD + 3) queue_item(random_item(MODE_TICK));
    drain(1'b1);

    $display("run covered %0d items and %0d checked results (%0d frames, %0d all-off)",
             items_accepted, results_checked, frames_seen, all_off_seen);
    $display("all four effects ran at reset, low and mid settings, plus a full breath cycle");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
